FILE: hw/rtl/gbba_pkg.sv
// Shared types and constants of the grouped block bitmap allocator.
// Depends on nothing; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package gbba_pkg;

    localparam int FIELD_W = 18;
    localparam int HINT_W  = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_GROUP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_COUNT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_BLOCK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITABLE         = 3'd4;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NOT_WRITABLE = 3'd1,
        ST_NO_SPACE     = 3'd2,
        ST_RANGE        = 3'd3,
        ST_ALREADY_FREE = 3'd4
    } t_status_code;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISP, S_HMOD, S_GMUL, S_GLIM, S_RD, S_EVAL, S_PICK,
        S_NEXTG, S_FCHK, S_FDIV, S_FRD, S_FEVAL, S_RES
    } t_state;

    typedef struct packed {
        logic         clr_wr;
        logic         latch;
        logic         hint_sub;
        logic         grp_mul;
        logic         grp_lim;
        logic         rd_scan;
        logic         eval;
        logic         scan_hit;
        logic         word_inc;
        logic         next_grp;
        logic         load_rem;
        logic         div_step;
        logic         rd_free;
        logic         free_clr;
        logic         set_st;
        t_status_code st;
        logic         out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic writable;
        logic kind;
        logic hint_ge_gc;
        logic lim_zero;
        logic found;
        logic more_words;
        logic last_group;
        logic range_bad;
        logic rem_ge_bpg;
        logic div_last;
        logic bit_set;
        logic out_free;
    } t_stat;

endpackage

FILE: hw/rtl/gbba_ctrl.sv
// Controller state machine of the grouped block bitmap allocator.
// Depends on gbba_pkg; drives gbba_datapath through command and status structs.
`timescale 1ns / 1ps

module gbba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  gbba_pkg::t_stat i_stat,
    output gbba_pkg::t_cmd  o_cmd
);

    gbba_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbba_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == gbba_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gbba_pkg::S_CLEAR: if (i_stat.clr_last) n_state = gbba_pkg::S_IDLE;
            gbba_pkg::S_IDLE:  if (i_in_valid) n_state = gbba_pkg::S_DISP;
            gbba_pkg::S_DISP: begin
                if (!i_stat.writable) n_state = gbba_pkg::S_RES;
                else if (i_stat.kind) n_state = gbba_pkg::S_FCHK;
                else n_state = gbba_pkg::S_HMOD;
            end
            gbba_pkg::S_HMOD:  if (!i_stat.hint_ge_gc) n_state = gbba_pkg::S_GMUL;
            gbba_pkg::S_GMUL:  n_state = gbba_pkg::S_GLIM;
            gbba_pkg::S_GLIM:  n_state = gbba_pkg::S_RD;
            gbba_pkg::S_RD: begin
                n_state = i_stat.lim_zero ? gbba_pkg::S_NEXTG : gbba_pkg::S_EVAL;
            end
            gbba_pkg::S_EVAL:  n_state = gbba_pkg::S_PICK;
            gbba_pkg::S_PICK: begin
                if (i_stat.found) n_state = gbba_pkg::S_RES;
                else if (i_stat.more_words) n_state = gbba_pkg::S_RD;
                else n_state = gbba_pkg::S_NEXTG;
            end
            gbba_pkg::S_NEXTG: begin
                n_state = i_stat.last_group ? gbba_pkg::S_RES : gbba_pkg::S_GMUL;
            end
            gbba_pkg::S_FCHK: begin
                n_state = i_stat.range_bad ? gbba_pkg::S_RES : gbba_pkg::S_FDIV;
            end
            gbba_pkg::S_FDIV: begin
                if (!i_stat.rem_ge_bpg) n_state = gbba_pkg::S_FRD;
                else if (i_stat.div_last) n_state = gbba_pkg::S_RES;
            end
            gbba_pkg::S_FRD:   n_state = gbba_pkg::S_FEVAL;
            gbba_pkg::S_FEVAL: n_state = gbba_pkg::S_RES;
            gbba_pkg::S_RES:   if (i_stat.out_free) n_state = gbba_pkg::S_IDLE;
            default:           n_state = gbba_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.st = gbba_pkg::ST_OK;
        unique case (r_state)
            gbba_pkg::S_CLEAR: o_cmd.clr_wr = 1'b1;
            gbba_pkg::S_IDLE:  o_cmd.latch = i_in_valid;
            gbba_pkg::S_DISP: begin
                if (!i_stat.writable) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st = gbba_pkg::ST_NOT_WRITABLE;
                end
            end
            gbba_pkg::S_HMOD:  o_cmd.hint_sub = i_stat.hint_ge_gc;
            gbba_pkg::S_GMUL:  o_cmd.grp_mul = 1'b1;
            gbba_pkg::S_GLIM:  o_cmd.grp_lim = 1'b1;
            gbba_pkg::S_RD:    o_cmd.rd_scan = !i_stat.lim_zero;
            gbba_pkg::S_EVAL:  o_cmd.eval = 1'b1;
            gbba_pkg::S_PICK: begin
                if (i_stat.found) begin
                    o_cmd.scan_hit = 1'b1;
                    o_cmd.set_st = 1'b1;
                    o_cmd.st = gbba_pkg::ST_OK;
                end else begin
                    o_cmd.word_inc = i_stat.more_words;
                end
            end
            gbba_pkg::S_NEXTG: begin
                if (i_stat.last_group) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st = gbba_pkg::ST_NO_SPACE;
                end else begin
                    o_cmd.next_grp = 1'b1;
                end
            end
            gbba_pkg::S_FCHK: begin
                if (i_stat.range_bad) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st = gbba_pkg::ST_RANGE;
                end else begin
                    o_cmd.load_rem = 1'b1;
                end
            end
            gbba_pkg::S_FDIV: begin
                if (i_stat.rem_ge_bpg) begin
                    if (i_stat.div_last) begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st = gbba_pkg::ST_RANGE;
                    end else begin
                        o_cmd.div_step = 1'b1;
                    end
                end
            end
            gbba_pkg::S_FRD:   o_cmd.rd_free = 1'b1;
            gbba_pkg::S_FEVAL: begin
                o_cmd.set_st = 1'b1;
                if (i_stat.bit_set) begin
                    o_cmd.free_clr = 1'b1;
                    o_cmd.st = gbba_pkg::ST_OK;
                end else begin
                    o_cmd.st = gbba_pkg::ST_ALREADY_FREE;
                end
            end
            gbba_pkg::S_RES:   o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

FILE: hw/rtl/gbba_datapath.sv
// Datapath of the grouped block bitmap allocator: configuration, bitmap memory,
// scan and free arithmetic, counter and output register. Depends on gbba_pkg.
`timescale 1ns / 1ps

module gbba_datapath #(
    parameter int MAX_GROUPS         = 16,
    parameter int MAX_BITS_PER_GROUP = 8192,
    parameter int WORD_BITS          = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [gbba_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gbba_pkg::FIELD_W-1:0]        i_cfg_data,
    input  logic                                i_kind,
    input  logic [gbba_pkg::HINT_W-1:0]         i_near_group,
    input  logic [gbba_pkg::FIELD_W-1:0]        i_block_to_free,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [2:0]                          o_status,
    output logic [gbba_pkg::FIELD_W-1:0]        o_granted_block,
    output logic [gbba_pkg::FIELD_W-1:0]        o_free_blocks,
    input  gbba_pkg::t_cmd                      i_cmd,
    output gbba_pkg::t_stat                     o_stat
);

    localparam int FW    = gbba_pkg::FIELD_W;
    localparam int GCW   = $clog2(MAX_GROUPS + 1);
    localparam int HW    = (GCW > gbba_pkg::HINT_W) ? GCW : gbba_pkg::HINT_W;
    localparam int BW    = $clog2(MAX_BITS_PER_GROUP + 1);
    localparam int WPG   = MAX_BITS_PER_GROUP / WORD_BITS;
    localparam int WIW   = (WPG > 1) ? $clog2(WPG) : 1;
    localparam int DEPTH = MAX_GROUPS * WPG;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = $clog2(WORD_BITS);
    localparam int PW    = GCW + BW;
    localparam int SW    = ((PW > FW) ? PW : FW) + 2;

    logic [4:0]    r_gc;
    logic [13:0]   r_bpg;
    logic [FW-1:0] r_bc;
    logic          r_fdb;
    logic          r_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gc  <= 5'd1;
            r_bpg <= 14'd8192;
            r_bc  <= 18'd8192;
            r_fdb <= 1'b0;
            r_wr  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                gbba_pkg::CFG_GROUP_COUNT:      r_gc  <= i_cfg_data[4:0];
                gbba_pkg::CFG_BLOCKS_PER_GROUP: r_bpg <= i_cfg_data[13:0];
                gbba_pkg::CFG_BLOCKS_COUNT:     r_bc  <= i_cfg_data;
                gbba_pkg::CFG_FIRST_DATA_BLOCK: r_fdb <= i_cfg_data[0];
                gbba_pkg::CFG_WRITABLE:         r_wr  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [GCW-1:0] gc_eff;
    logic [BW-1:0]  bpg_eff;

    always_comb begin
        if (r_gc == 5'd0) gc_eff = GCW'(1);
        else if (32'(r_gc) > MAX_GROUPS) gc_eff = GCW'(MAX_GROUPS);
        else gc_eff = GCW'(r_gc);
        if (r_bpg < 14'd8) bpg_eff = BW'(8);
        else if (32'(r_bpg) > MAX_BITS_PER_GROUP) bpg_eff = BW'(MAX_BITS_PER_GROUP);
        else bpg_eff = BW'(r_bpg);
    end

    logic                 r_kind;
    logic [HW-1:0]        r_grp;
    logic [GCW-1:0]       r_gi;
    logic [FW-1:0]        r_blk;
    logic [FW-1:0]        r_rem;
    logic [PW-1:0]        r_base;
    logic [BW-1:0]        r_limit;
    logic [WIW-1:0]       r_word;
    logic [WORD_BITS-1:0] r_masked;
    logic [WORD_BITS-1:0] r_rdata;
    logic [AW-1:0]        r_clr;
    logic [FW-1:0]        r_alloc;
    gbba_pkg::t_status_code r_st;
    logic [FW-1:0]        r_granted;
    logic                 r_out_valid;
    logic [2:0]           r_out_status;
    logic [FW-1:0]        r_out_granted;
    logic [FW-1:0]        r_out_free;

    logic [WORD_BITS-1:0] mem [DEPTH];

    logic [GCW-1:0]        grp_idx;
    logic                  grp_last;
    logic signed [SW-1:0]  rem_s;
    logic [BW-1:0]         limit_n;
    logic [BW-1:0]         wbase;
    logic [BW-1:0]         rel;
    logic [WORD_BITS-1:0]  masked_n;
    logic [KW-1:0]         pos;
    logic [KW-1:0]         fbit;
    logic [WIW-1:0]        fword;
    logic [AW-1:0]         addr;
    logic                  mem_we;
    logic [WORD_BITS-1:0]  mem_wdata;
    logic [FW-1:0]         usable;
    logic [FW-1:0]         free_n;

    assign grp_idx  = GCW'(r_grp);
    assign grp_last = (grp_idx == gc_eff - GCW'(1));
    assign rem_s    = $signed(SW'(r_bc)) - $signed(SW'(r_fdb)) - $signed(SW'(r_base));
    assign wbase    = BW'({r_word, {KW{1'b0}}});
    assign rel      = r_limit - wbase;
    assign fbit     = r_rem[KW-1:0];
    assign fword    = r_rem[KW +: WIW];

    always_comb begin
        if (!grp_last) limit_n = bpg_eff;
        else if (rem_s < 0) limit_n = '0;
        else if (rem_s > $signed(SW'(bpg_eff))) limit_n = bpg_eff;
        else limit_n = BW'(rem_s);
    end

    always_comb begin
        for (int k = 0; k < WORD_BITS; k++) begin
            masked_n[k] = (32'(rel) <= k) ? 1'b1 : r_rdata[k];
        end
    end

    always_comb begin
        pos = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (!r_masked[k]) pos = KW'(k);
        end
    end

    always_comb begin
        if (i_cmd.clr_wr) addr = r_clr;
        else if (r_kind) addr = AW'(32'(grp_idx) * WPG + 32'(fword));
        else addr = AW'(32'(grp_idx) * WPG + 32'(r_word));
    end

    assign mem_we = i_cmd.clr_wr | i_cmd.scan_hit | i_cmd.free_clr;

    always_comb begin
        if (i_cmd.clr_wr) mem_wdata = '0;
        else if (i_cmd.scan_hit) mem_wdata = r_rdata | (WORD_BITS'(1) << pos);
        else mem_wdata = r_rdata & ~(WORD_BITS'(1) << fbit);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[addr] <= mem_wdata;
        if (i_cmd.rd_scan | i_cmd.rd_free) r_rdata <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind    <= i_kind;
            r_grp     <= HW'(i_near_group);
            r_blk     <= i_block_to_free;
            r_gi      <= '0;
            r_granted <= '0;
        end
        if (i_cmd.hint_sub) r_grp <= r_grp - HW'(gc_eff);
        if (i_cmd.grp_mul) r_base <= PW'(grp_idx) * PW'(bpg_eff);
        if (i_cmd.grp_lim) begin
            r_limit <= limit_n;
            r_word  <= '0;
        end
        if (i_cmd.eval) r_masked <= masked_n;
        if (i_cmd.word_inc) r_word <= r_word + WIW'(1);
        if (i_cmd.next_grp) begin
            r_gi  <= r_gi + GCW'(1);
            r_grp <= grp_last ? '0 : r_grp + HW'(1);
        end
        if (i_cmd.scan_hit) begin
            r_granted <= FW'(32'(r_fdb) + 32'(r_base) + 32'(wbase) + 32'(pos));
        end
        if (i_cmd.load_rem) begin
            r_rem <= r_blk - FW'(r_fdb);
            r_grp <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= r_rem - FW'(bpg_eff);
            r_grp <= r_grp + HW'(1);
        end
        if (i_cmd.set_st) r_st <= i_cmd.st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc <= '0;
        end else if (i_cmd.scan_hit) begin
            if (r_alloc != {FW{1'b1}}) r_alloc <= r_alloc + FW'(1);
        end else if (i_cmd.free_clr) begin
            if (r_alloc != '0) r_alloc <= r_alloc - FW'(1);
        end
    end

    assign usable = (r_bc > FW'(r_fdb)) ? r_bc - FW'(r_fdb) : '0;
    assign free_n = (usable > r_alloc) ? usable - r_alloc : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status  <= r_st;
            r_out_granted <= r_granted;
            r_out_free    <= free_n;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_granted_block = r_out_granted;
    assign o_free_blocks   = r_out_free;

    always_comb begin
        o_stat.clr_last   = (r_clr == AW'(DEPTH - 1));
        o_stat.writable   = r_wr;
        o_stat.kind       = r_kind;
        o_stat.hint_ge_gc = (r_grp >= HW'(gc_eff));
        o_stat.lim_zero   = (r_limit == '0);
        o_stat.found      = !(&r_masked);
        o_stat.more_words = (32'(wbase) + WORD_BITS) < 32'(r_limit);
        o_stat.last_group = (r_gi + GCW'(1) == gc_eff);
        o_stat.range_bad  = (r_blk < FW'(r_fdb)) || (r_blk >= r_bc);
        o_stat.rem_ge_bpg = (r_rem >= FW'(bpg_eff));
        o_stat.div_last   = grp_last;
        o_stat.bit_set    = r_rdata[fbit];
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

`ifndef SYNTHESIS
    a_free_clears_set_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.free_clr |-> r_rdata[fbit])
        else $error("clearing a bit that is not set");
    a_grant_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && r_st != gbba_pkg::ST_OK) |-> (r_granted == '0))
        else $error("granted block not zero on failed request");
    a_hit_counts_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_hit |=> (r_alloc >= $past(r_alloc)))
        else $error("allocated count fell on a grant");
`endif

endmodule

FILE: hw/rtl/grouped_block_bitmap_allocator.sv
// Top level of the grouped block bitmap allocator: ports, controller and datapath.
// Depends on gbba_pkg, gbba_ctrl and gbba_datapath.
//
// Usage: a request item (kind, near group, block_to_free) enters on the input
// valid/ready channel; exactly one result item (status, granted_block,
// free_blocks) leaves on the output valid/ready channel for each request.
// Configuration is written through i_cfg_wr_en/i_cfg_idx/i_cfg_data while idle.
// Steps from accepting a request to loading its result: a not-writable request
// goes from dispatch straight to the result step; a free checks the range,
// steps over groups in the block-to-group reduction, then reads and evaluates
// the bitmap word; an allocate reduces the hint, then for each group visited
// computes base and limit and reads and evaluates one bitmap word at a time
// until a free bit is found, else moves on to the next group.
// One request is worked on at a time; the next is taken once the result sits
// in the output register, even while that result waits for the receiver.
// Reset: the bitmap memory is cleared one word a cycle, all MAX_GROUPS *
// MAX_BITS_PER_GROUP / WORD_BITS words (2048 by default), with input ready
// low; configuration returns to its reset values and the counter to zero.
// Receiver stall: the result holds in the output register; a further result
// waits in its final step until the register is taken.
`timescale 1ns / 1ps

module grouped_block_bitmap_allocator #(
    parameter int MAX_GROUPS         = 16,
    parameter int MAX_BITS_PER_GROUP = 8192,
    parameter int WORD_BITS          = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [gbba_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gbba_pkg::FIELD_W-1:0]   i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_kind,
    input  logic [gbba_pkg::HINT_W-1:0]    i_near_group,
    input  logic [gbba_pkg::FIELD_W-1:0]   i_block_to_free,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [2:0]                     o_status,
    output logic [gbba_pkg::FIELD_W-1:0]   o_granted_block,
    output logic [gbba_pkg::FIELD_W-1:0]   o_free_blocks
);

    gbba_pkg::t_cmd  cmd;
    gbba_pkg::t_stat stat;

    gbba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gbba_datapath #(
        .MAX_GROUPS         (MAX_GROUPS),
        .MAX_BITS_PER_GROUP (MAX_BITS_PER_GROUP),
        .WORD_BITS          (WORD_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_near_group    (i_near_group),
        .i_block_to_free (i_block_to_free),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_granted_block (o_granted_block),
        .o_free_blocks   (o_free_blocks),
        .i_cmd           (cmd),
        .o_stat          (stat)
    );

endmodule
